// ===== sv/tx_power_detect_calc_core_macros.svh =====
// ============================================================================
// Assertion macros for the transmit power detect core
// Each macro expands to one labeled concurrent assertion clocked on i_clk
// and disabled while i_rst_n is low; empty when SYNTHESIS is defined.
// ============================================================================
`ifndef TX_POWER_DETECT_CALC_CORE_MACROS_SVH
`define TX_POWER_DETECT_CALC_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPD_ASSERT_IMP(lbl, ante, cons, msg)
`define TPD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/tpd_pkg.sv =====
// ============================================================================
// tpd_pkg
// Types, widths and constants shared by the transmit power detect modules.
// ============================================================================
package tpd_pkg;

    // sizing
    localparam int BEAMS       = 45;
    localparam int SUM_SLOTS   = 16;
    localparam int ANTENNAS    = 2;
    localparam int ANT_W       = (ANTENNAS > 1) ? $clog2(ANTENNAS) : 1;
    localparam int COEF_DEPTH  = BEAMS * ANTENNAS;
    localparam int ADDR_W      = $clog2(COEF_DEPTH);
    localparam int QUEUE_DEPTH = 4;

    // field widths
    localparam int SLOT_W      = 6;
    localparam int READING_W   = 32;
    localparam int CNT_W       = 28;
    localparam int COEF_W      = 24;
    localparam int TICK_W      = 8;
    localparam int SLOPE_W     = 20;
    localparam int OFFSET_W    = 20;
    localparam int CFG_W       = 20;
    localparam int PWR_W       = 20;

    // datapath widths
    localparam int WSUM_W      = 64;
    localparam int PSUM_W      = 32;
    localparam int CPROD_W     = COEF_W + CNT_W + 1;
    localparam int OFFSET_SHIFT = 21;
    localparam int SP_W        = SLOPE_W + PSUM_W;
    localparam int DM10_W      = SP_W + 4;
    localparam int PROD_W      = WSUM_W + DM10_W;
    localparam int MUL_A_W     = WSUM_W / 2;
    localparam int MUL_B_W     = DM10_W / 2;
    localparam int PP_W        = MUL_A_W + MUL_B_W;
    localparam int PWR_SHIFT   = 70;
    localparam int RND_BIT     = PWR_SHIFT - 1;

    localparam logic [CNT_W-1:0]  CNT_INVALID = '1;
    localparam logic [WSUM_W-1:0] WSUM_MAX    = {1'b0, {(WSUM_W-1){1'b1}}};
    localparam logic [WSUM_W-1:0] WSUM_MIN    = {1'b1, {(WSUM_W-1){1'b0}}};

    // register reset values
    localparam logic [TICK_W-1:0]   TIMEOUT_RST = 8'd20;
    localparam logic [SLOPE_W-1:0]  SLOPE_RST   = 20'd6947;
    localparam logic [OFFSET_W-1:0] OFFSET_RST  = 20'd186778;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_SUM   = 2'd2,
        MODE_COEF  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OC_START   = 2'd0,
        OC_TIMEOUT = 2'd1,
        OC_POWER   = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_SLOPE   = 2'd1,
        CFG_OFFSET  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_mode                    mode;
        logic                     ready_req;
        logic                     antenna;
        logic [SLOT_W-1:0]        slot;
        logic [READING_W-1:0]     reading;
        logic signed [COEF_W-1:0] coefficient;
    } t_in_item;

    typedef struct packed {
        t_outcome           outcome;
        logic               result_antenna;
        logic [PWR_W-1:0]   power_tenths;
        logic               clipped;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0]   timeout_ticks;
        logic [SLOPE_W-1:0]  slope_q16;
        logic [OFFSET_W-1:0] offset_q16;
    } t_cfg;

    // classified command passed from front to back
    typedef struct packed {
        t_mode              op;
        logic               ready;
        logic [ANT_W-1:0]   ant;
        logic [ADDR_W-1:0]  addr;
        logic [CNT_W-1:0]   data;
    } t_cmd;

    typedef struct packed {
        logic  empty;
        t_cmd  head;
    } t_q_stat;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_CNT_MUL,
        BS_CNT_ADD,
        BS_SUM_ADD,
        BS_PD_MUL,
        BS_PD_SUB,
        BS_PD_PREP,
        BS_PD_RUN,
        BS_PD_EMIT
    } t_bstate;

endpackage

// ===== sv/tpd_front.sv =====
// ============================================================================
// tpd_front
// Input stage: accepts transactions, range-checks them, drops items with no
// effect and hands the rest to the command queue.
// ============================================================================
module tpd_front import tpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic             r_valid;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic             n_keep;
    logic             ant_ok;
    logic             beam_ok;
    logic             sum_ok;
    logic [CNT_W-1:0] cnt;
    logic             accept;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        ant_ok  = 32'(i_in.antenna) < ANTENNAS;
        beam_ok = 32'(i_in.slot) < BEAMS;
        sum_ok  = 32'(i_in.slot) < SUM_SLOTS;
        cnt     = i_in.reading[CNT_W-1:0];
        n_cmd.op    = i_in.mode;
        n_cmd.ready = i_in.ready_req;
        n_cmd.ant   = ANT_W'(i_in.antenna);
        n_cmd.addr  = '0;
        n_cmd.data  = cnt;
        case (i_in.mode)
            MODE_TICK: begin
                n_keep = 1'b1;
            end
            MODE_COUNT: begin
                n_keep     = beam_ok && ant_ok && (cnt != CNT_INVALID);
                n_cmd.addr = ADDR_W'(32'(i_in.slot) * ANTENNAS + 32'(i_in.antenna));
            end
            MODE_SUM: begin
                n_keep = sum_ok && ant_ok;
            end
            MODE_COEF: begin
                n_keep     = beam_ok && ant_ok;
                n_cmd.addr = ADDR_W'(32'(i_in.slot) * ANTENNAS + 32'(i_in.antenna));
                n_cmd.data = CNT_W'(i_in.coefficient);
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= n_keep;
        end else if (!i_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== sv/tpd_queue.sv =====
// ============================================================================
// tpd_queue
// Short command FIFO between front and back.
// ============================================================================
module tpd_queue import tpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic [PTR_W-1:0]  wr_next;
    logic [PTR_W-1:0]  rd_next;

    assign o_full       = r_count == CNT_QW'(QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_stat.head  = r_mem[r_rd_ptr];
    assign wr_next = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= wr_next;
            end
            if (i_pop) begin
                r_rd_ptr <= rd_next;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/tpd_pwr_mul.sv =====
// ============================================================================
// tpd_pwr_mul
// Multi-cycle |W| x 10|D| multiply from four 32x28 partial products, then
// round at bit 69, shift by 70 and saturate to the power field.
// ============================================================================
module tpd_pwr_mul import tpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WSUM_W-1:0] i_mag_w,
    input  logic [DM10_W-1:0] i_mag_d10,
    output logic              o_done,
    output logic [PWR_W-1:0]  o_power
);

    logic                r_busy;
    logic [2:0]          r_step;
    logic                r_done;
    logic [WSUM_W-1:0]   r_a;
    logic [DM10_W-1:0]   r_b;
    logic [PP_W-1:0]     r_pp;
    logic [1:0]          r_pp_sel;
    logic                r_pp_vld;
    logic [PROD_W-1:0]   r_acc;
    logic [PWR_W-1:0]    r_power;
    logic [MUL_A_W-1:0]  a_part;
    logic [MUL_B_W-1:0]  b_part;
    logic [PP_W-1:0]     n_pp;
    logic [PROD_W-1:0]   pp_shifted;
    logic [PROD_W-1:0]   n_acc;
    logic [PROD_W:0]     rnd;

    assign o_done  = r_done;
    assign o_power = r_power;

    always_comb begin
        a_part = r_step[1] ? r_a[WSUM_W-1:MUL_A_W] : r_a[MUL_A_W-1:0];
        b_part = r_step[0] ? r_b[DM10_W-1:MUL_B_W] : r_b[MUL_B_W-1:0];
        n_pp   = PP_W'(a_part) * PP_W'(b_part);
        case (r_pp_sel)
            2'd0:    pp_shifted = PROD_W'(r_pp);
            2'd1:    pp_shifted = PROD_W'(r_pp) << MUL_B_W;
            2'd2:    pp_shifted = PROD_W'(r_pp) << MUL_A_W;
            2'd3:    pp_shifted = PROD_W'(r_pp) << (MUL_A_W + MUL_B_W);
            default: pp_shifted = '0;
        endcase
        n_acc = r_acc + (r_pp_vld ? pp_shifted : '0);
        rnd   = (PROD_W+1)'(r_acc) + ((PROD_W+1)'(1) << RND_BIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= '0;
            r_done   <= 1'b0;
            r_pp_vld <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_step   <= '0;
                r_pp_vld <= 1'b0;
            end else if (r_busy) begin
                if (r_step < 3'd4) begin
                    r_pp_vld <= 1'b1;
                    r_step   <= r_step + 1'b1;
                end else if (r_step == 3'd4) begin
                    r_pp_vld <= 1'b0;
                    r_step   <= 3'd5;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_mag_w;
            r_b   <= i_mag_d10;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            if (r_step < 3'd4) begin
                r_pp     <= n_pp;
                r_pp_sel <= r_step[1:0];
            end
            if (r_step == 3'd5) begin
                // anything at or above 2^20 after the shift saturates
                r_power <= (|rnd[PROD_W:PWR_SHIFT+PWR_W]) ? '1
                                                           : rnd[PWR_SHIFT+PWR_W-1:PWR_SHIFT];
            end
        end
    end

endmodule

// ===== sv/tpd_back.sv =====
// ============================================================================
// tpd_back
// Execution side: coefficient table, accumulators, tick sequencing, power
// computation per antenna and the output register.
// ============================================================================
module tpd_back import tpd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_stat   i_q,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_bstate                    r_state;
    t_bstate                    n_state;
    t_cmd                       r_cmd;
    logic [ANT_W-1:0]           r_ant;
    logic [ANT_W-1:0]           n_ant;
    logic [TICK_W-1:0]          r_tick;
    logic [TICK_W-1:0]          n_tick;
    logic signed [WSUM_W-1:0]   r_wsum [ANTENNAS];
    logic [PSUM_W-1:0]          r_psum [ANTENNAS];
    logic [COEF_W-1:0]          r_coef_mem [COEF_DEPTH];
    logic [COEF_W-1:0]          r_coef_rd;
    logic signed [CPROD_W-1:0]  r_prod;
    logic [SP_W-1:0]            r_sp;
    logic [SP_W-1:0]            r_dm;
    logic                       r_dneg;
    logic                       r_dzero;
    logic signed [WSUM_W-1:0]   r_w;
    logic                       r_clip;
    logic                       r_zero;
    logic [PWR_W-1:0]           r_pw;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic                       out_free;
    logic                       head_ok;
    logic                       last_ant;
    logic                       mem_we;
    logic                       pwr_start;
    logic                       pwr_done;
    logic [PWR_W-1:0]           pwr_value;
    logic                       out_load;
    t_out_item                  out_data;
    logic                       wsum_we;
    logic [WSUM_W-1:0]          wsum_val;
    logic                       psum_we;
    logic [PSUM_W-1:0]          psum_val;
    logic signed [WSUM_W-1:0]   wsum_cur;
    logic [PSUM_W-1:0]          psum_cur;
    logic [WSUM_W:0]            wsum_add;
    logic [WSUM_W-1:0]          wsum_sat;
    logic [PSUM_W:0]            psum_add;
    logic [PSUM_W-1:0]          psum_sat;
    logic [SP_W-1:0]            off_ext;
    logic [WSUM_W-1:0]          w_mag;
    logic [DM10_W-1:0]          d10;
    logic                       skip;
    logic                       clip;
    logic [TICK_W-1:0]          tick_inc;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign head_ok     = !i_q.empty && ((i_q.head.op != MODE_TICK) || out_free);
    assign last_ant    = r_ant == ANT_W'(ANTENNAS - 1);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // shared datapath pieces; the accumulator reads are indexed by r_ant
    always_comb begin
        wsum_cur = r_wsum[r_ant];
        psum_cur = r_psum[r_ant];
        wsum_add = {wsum_cur[WSUM_W-1], wsum_cur}
                 + {{(WSUM_W+1-CPROD_W){r_prod[CPROD_W-1]}}, r_prod};
        if (wsum_add[WSUM_W] != wsum_add[WSUM_W-1]) begin
            wsum_sat = wsum_add[WSUM_W] ? WSUM_MIN : WSUM_MAX;
        end else begin
            wsum_sat = wsum_add[WSUM_W-1:0];
        end
        psum_add = (PSUM_W+1)'(psum_cur) + (PSUM_W+1)'(r_cmd.data);
        psum_sat = psum_add[PSUM_W] ? '1 : psum_add[PSUM_W-1:0];
        off_ext  = SP_W'({i_cfg.offset_q16, {OFFSET_SHIFT{1'b0}}});
        w_mag    = r_w[WSUM_W-1] ? WSUM_W'(0) - WSUM_W'(r_w) : WSUM_W'(r_w);
        d10      = (DM10_W'(r_dm) << 3) + (DM10_W'(r_dm) << 1);
        skip     = (r_w == '0) || r_dzero;
        clip     = !skip && (r_w[WSUM_W-1] != r_dneg);
        tick_inc = (r_tick == '1) ? r_tick : r_tick + 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (head_ok) begin
                    case (i_q.head.op)
                        MODE_COUNT: n_state = BS_CNT_MUL;
                        MODE_SUM:   n_state = BS_SUM_ADD;
                        MODE_TICK: begin
                            if ((r_tick != '0) && i_q.head.ready) begin
                                n_state = BS_PD_MUL;
                            end
                        end
                        default:    n_state = BS_IDLE;
                    endcase
                end
            end
            BS_CNT_MUL: n_state = BS_CNT_ADD;
            BS_CNT_ADD: n_state = BS_IDLE;
            BS_SUM_ADD: n_state = BS_IDLE;
            BS_PD_MUL:  n_state = BS_PD_SUB;
            BS_PD_SUB:  n_state = BS_PD_PREP;
            BS_PD_PREP: n_state = BS_PD_RUN;
            BS_PD_RUN: begin
                if (r_zero || pwr_done) begin
                    n_state = BS_PD_EMIT;
                end
            end
            BS_PD_EMIT: begin
                if (out_free) begin
                    n_state = last_ant ? BS_IDLE : BS_PD_MUL;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // control and data outputs of each state
    always_comb begin
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        pwr_start = 1'b0;
        out_load  = 1'b0;
        out_data  = '{outcome: OC_START, result_antenna: 1'b0, power_tenths: '0,
                      clipped: 1'b0, last: 1'b1};
        wsum_we   = 1'b0;
        wsum_val  = wsum_sat;
        psum_we   = 1'b0;
        psum_val  = psum_sat;
        n_tick    = r_tick;
        n_ant     = r_ant;
        case (r_state)
            BS_IDLE: begin
                if (head_ok) begin
                    o_q_pop = 1'b1;
                    case (i_q.head.op)
                        MODE_COEF: begin
                            mem_we = 1'b1;
                        end
                        MODE_COUNT, MODE_SUM: begin
                            n_ant = i_q.head.ant;
                        end
                        MODE_TICK: begin
                            if (r_tick == '0) begin
                                n_tick   = TICK_W'(1);
                                out_load = 1'b1;
                            end else begin
                                n_tick = tick_inc;
                                if (!i_q.head.ready) begin
                                    if (r_tick >= i_cfg.timeout_ticks) begin
                                        n_tick           = '0;
                                        out_load         = 1'b1;
                                        out_data.outcome = OC_TIMEOUT;
                                    end
                                end else begin
                                    n_ant = '0;
                                end
                            end
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_CNT_ADD: begin
                wsum_we = 1'b1;
            end
            BS_SUM_ADD: begin
                psum_we = 1'b1;
            end
            BS_PD_PREP: begin
                pwr_start = !skip && !clip;
            end
            BS_PD_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = '{outcome: OC_POWER, result_antenna: 1'(r_ant),
                                 power_tenths: r_pw, clipped: r_clip, last: last_ant};
                    wsum_we  = 1'b1;
                    wsum_val = '0;
                    psum_we  = 1'b1;
                    psum_val = '0;
                    if (last_ant) begin
                        n_tick = '0;
                    end else begin
                        n_ant = ANT_W'(r_ant + 1'b1);
                    end
                end
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    tpd_pwr_mul u_pwr_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (pwr_start),
        .i_mag_w   (w_mag),
        .i_mag_d10 (d10),
        .o_done    (pwr_done),
        .o_power   (pwr_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_tick      <= '0;
            r_ant       <= '0;
            r_out_valid <= 1'b0;
            for (int a = 0; a < ANTENNAS; a++) begin
                r_wsum[a] <= '0;
                r_psum[a] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_ant   <= n_ant;
            if (wsum_we) begin
                r_wsum[r_ant] <= wsum_val;
            end
            if (psum_we) begin
                r_psum[r_ant] <= psum_val;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // coefficient table, registered read at the queue head address
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_coef_mem[i_q.head.addr] <= i_q.head.data[COEF_W-1:0];
        end
        r_coef_rd <= r_coef_mem[i_q.head.addr];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q.head;
        end
        if (out_load) begin
            r_out <= out_data;
        end
        case (r_state)
            BS_CNT_MUL: begin
                r_prod <= $signed(r_coef_rd) * $signed({1'b0, r_cmd.data});
            end
            BS_PD_MUL: begin
                r_sp <= SP_W'(i_cfg.slope_q16) * SP_W'(psum_cur);
                r_w  <= wsum_cur;
            end
            BS_PD_SUB: begin
                r_dzero <= r_sp == off_ext;
                r_dneg  <= r_sp < off_ext;
                r_dm    <= (r_sp >= off_ext) ? r_sp - off_ext : off_ext - r_sp;
            end
            BS_PD_PREP: begin
                r_clip <= clip;
                r_zero <= skip || clip;
            end
            BS_PD_RUN: begin
                r_pw <= r_zero ? '0 : pwr_value;
            end
            default: begin
                r_pw <= r_pw;
            end
        endcase
    end

endmodule

// ===== sv/tx_power_detect_calc_core.sv =====
// ============================================================================
// tx_power_detect_calc_core
// Two-antenna transmit power measurement with beam-weighted counts.
// Input channel (i_in_valid / o_in_stall / i_in): one transaction per item;
// mode selects tick, beam count, power sum or coefficient load. Output
// channel (o_out_valid / i_out_stall / o_out): result transactions; a tick
// gives a start or timeout result, or one power result per antenna.
// Config: i_cfg_we writes timeout, slope or offset; the user must write only
// while idle, as the block itself does not enforce it. Each command passes
// the front register and the queue; counts then go through a table read, a
// 24x28 multiply and a saturating add. A ready tick handles each antenna in
// turn: slope multiply, offset subtract, sign check, the 64x56 product built
// from four 32x28 passes (skipped when the power is zero or clipped), emit.
// A four-entry command queue lets the input keep flowing while the back
// end computes or the output is stalled; input stalls only when it fills.
// Output is one register: a stalled result holds and the back end waits.
// Reset (synchronous, active low) clears tick count, accumulators, queue
// and loads default config; the coefficient table is not cleared.
// ============================================================================
`include "tx_power_detect_calc_core_macros.svh"

module tx_power_detect_calc_core import tpd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_cfg    r_cfg;
    logic    q_push;
    t_cmd    q_cmd;
    logic    q_full;
    logic    q_pop;
    t_q_stat q_stat;

    // config registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= TIMEOUT_RST;
            r_cfg.slope_q16     <= SLOPE_RST;
            r_cfg.offset_q16    <= OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_wdata[TICK_W-1:0];
                CFG_SLOPE:   r_cfg.slope_q16     <= i_cfg_wdata[SLOPE_W-1:0];
                CFG_OFFSET:  r_cfg.offset_q16    <= i_cfg_wdata[OFFSET_W-1:0];
                default:     r_cfg               <= r_cfg;
            endcase
        end
    end

    // front: accept and classify
    tpd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_cmd)
    );

    // decoupling queue
    tpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_stat  (q_stat)
    );

    // back: execute and report
    tpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q         (q_stat),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // checks
    `TPD_ASSERT_IMP(a_pop_nonempty, q_pop, !q_stat.empty, "command popped from empty queue")
    `TPD_ASSERT_NXT(a_push_fills, q_push, !q_stat.empty, "pushed command lost by queue")
    `TPD_ASSERT_IMP(a_clip_zero, o_out_valid && o_out.clipped, o_out.power_tenths == '0, "clipped result has nonzero power")
    `TPD_ASSERT_IMP(a_status_fields, o_out_valid && (o_out.outcome != OC_POWER), o_out.last && !o_out.clipped && (o_out.power_tenths == '0), "status result with power fields set")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Transmit power detect core testbench
// Drives beam counts, power sums, coefficient loads and ticks through the
// valid/stall input channel, keeps its own copy of the accumulators and the
// measurement state, and checks every result transaction field by field.
// Runs a directed table, random phases under several register settings and
// idle patterns, and a power sum saturation run.
// ============================================================================
module testbench;
    import tpd_pkg::*;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in        = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out;
    logic             i_cfg_we    = 1'b0;
    logic [1:0]       i_cfg_idx   = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    tx_power_detect_calc_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop; the slowest legal run is far below this.
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    localparam logic [PWR_W-1:0] PWR_MAX     = '1;
    localparam int               N_DIRECTED  = 22;
    localparam int               PHASE_ITEMS = 190;
    localparam int               HOLD_CYCLES = 300;
    localparam int               SAT_ROUNDS  = 8;      // large weighted sums, both signs

    // Directed stimulus row; typed rows carry their result inline
    // (OC_POWER typed means both antennas report zero power).
    typedef struct packed {
        t_in_item item;
        logic     typed;
        t_outcome typed_oc;
    } t_step_row;

    // ------------------------------------------------------------------------
    // Power detector state as seen by the testbench
    // ------------------------------------------------------------------------
    logic [TICK_W-1:0]          cfg_timeout;
    logic [SLOPE_W-1:0]         cfg_slope;
    logic [OFFSET_W-1:0]        cfg_offset;
    logic [TICK_W-1:0]          tick_cnt;
    logic signed [COEF_W-1:0]   gain_table   [BEAMS][ANTENNAS];
    bit                         gain_written [BEAMS][ANTENNAS];
    logic signed [WSUM_W-1:0]   weighted_acc [ANTENNAS];
    logic [PSUM_W-1:0]          power_acc    [ANTENNAS];

    t_out_item pending_results[$];   // expected result transactions, oldest first
    int        mismatch_count = 0;

    // Idle pattern, percent of cycles / items
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Long receiver hold-off: main bumps hold_requests, the receiver serves it
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // ------------------------------------------------------------------------
    // Arithmetic of the detector
    // ------------------------------------------------------------------------
    function automatic logic signed [WSUM_W-1:0] sat_add(input logic signed [WSUM_W-1:0] x,
                                                         input logic signed [WSUM_W-1:0] y);
        logic [WSUM_W:0] s;
        s = {x[WSUM_W-1], x} + {y[WSUM_W-1], y};
        if (s[WSUM_W] != s[WSUM_W-1])
            return s[WSUM_W] ? WSUM_MIN : WSUM_MAX;
        return s[WSUM_W-1:0];
    endfunction

    // power = W * (slope*S - offset*2^21) / 2^70 mW, reported in tenths
    function automatic void power_of(input int a, output logic [PWR_W-1:0] pw,
                                     output logic clip);
        logic signed [63:0] w, d;
        logic [63:0]        sp, op, wm, dm;
        logic [127:0]       prod;
        w    = weighted_acc[a];
        sp   = 64'(cfg_slope) * 64'(power_acc[a]);
        op   = 64'(cfg_offset) << OFFSET_SHIFT;
        d    = $signed(sp - op);
        pw   = '0;
        clip = 1'b0;
        if (w != 0 && d != 0) begin
            if (w[63] != d[63]) begin
                clip = 1'b1;
            end else begin
                wm   = w[63] ? -w : w;
                dm   = d[63] ? -d : d;
                prod = 128'(wm) * 128'(dm) * 128'd10;
                prod = (prod + (128'd1 << RND_BIT)) >> PWR_SHIFT;
                pw   = (prod[127:PWR_W] != 0) ? PWR_MAX : prod[PWR_W-1:0];
            end
        end
    endfunction

    // Advances the detector state by one transaction; keep queues its results.
    task automatic predict_item(input t_in_item it, input bit keep);
        logic [CNT_W-1:0]        val;
        logic signed [WSUM_W-1:0] g64, v64;
        logic [PSUM_W:0]         ps;
        logic [TICK_W-1:0]       prior;
        logic [PWR_W-1:0]        pw;
        logic                    clip;
        t_out_item               r;
        val = it.reading[CNT_W-1:0];
        r   = '0;
        case (it.mode)
            MODE_COEF: begin
                if (it.slot < BEAMS) begin
                    gain_table[it.slot][it.antenna]   = it.coefficient;
                    gain_written[it.slot][it.antenna] = 1'b1;
                end
            end
            MODE_COUNT: begin
                // all-ones count means the counter read was invalid
                if (it.slot < BEAMS && val != CNT_INVALID) begin
                    g64 = gain_table[it.slot][it.antenna];
                    v64 = {36'd0, val};
                    weighted_acc[it.antenna] = sat_add(weighted_acc[it.antenna], g64 * v64);
                end
            end
            MODE_SUM: begin
                if (it.slot < SUM_SLOTS) begin
                    ps = {1'b0, power_acc[it.antenna]} + (PSUM_W+1)'(val);
                    power_acc[it.antenna] = ps[PSUM_W] ? '1 : ps[PSUM_W-1:0];
                end
            end
            default: begin
                if (tick_cnt == 0) begin
                    tick_cnt  = 1;
                    r.outcome = OC_START;
                    r.last    = 1'b1;
                    if (keep) pending_results.push_back(r);
                end else begin
                    prior = tick_cnt;
                    if (tick_cnt != '1) tick_cnt++;
                    if (!it.ready_req) begin
                        if (prior >= cfg_timeout) begin
                            tick_cnt  = 0;
                            r.outcome = OC_TIMEOUT;
                            r.last    = 1'b1;
                            if (keep) pending_results.push_back(r);
                        end
                    end else begin
                        for (int a = 0; a < ANTENNAS; a++) begin
                            power_of(a, pw, clip);
                            r.outcome        = OC_POWER;
                            r.result_antenna = a[0];
                            r.power_tenths   = pw;
                            r.clipped        = clip;
                            r.last           = (a == ANTENNAS - 1);
                            if (keep) pending_results.push_back(r);
                            weighted_acc[a] = '0;
                            power_acc[a]    = '0;
                        end
                        tick_cnt = 0;
                    end
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item mk(input t_mode m, input logic rdy, input logic a,
                                    input logic [SLOT_W-1:0] s,
                                    input logic [READING_W-1:0] rd,
                                    input logic [COEF_W-1:0] c);
        t_in_item it;
        it.mode        = m;
        it.ready_req   = rdy;
        it.antenna     = a;
        it.slot        = s;
        it.reading     = rd;
        it.coefficient = c;
        return it;
    endfunction

    // Directed table. Unused fields carry junk on purpose.
    function automatic t_step_row directed_row(input int n);
        t_step_row r;
        r.item     = '0;
        r.typed    = 1'b0;
        r.typed_oc = OC_START;
        case (n)
            // measurement start, then empty measurement, then restart
            0:  begin r.item = mk(MODE_TICK, 0, 1, 6'd63, '1, '1); r.typed = 1; end
            1:  begin r.item = mk(MODE_TICK, 1, 0, 6'd0, '1, '1);
                      r.typed = 1; r.typed_oc = OC_POWER; end
            2:  begin r.item = mk(MODE_TICK, 1, 1, 6'd0, '0, '0); r.typed = 1; end
            // coefficient extremes, out-of-range beams ignored
            3:  r.item = mk(MODE_COEF,  1, 0, 6'd0,  '1, 24'h7FFFFF);
            4:  r.item = mk(MODE_COEF,  1, 1, 6'd44, '1, 24'h800000);
            5:  r.item = mk(MODE_COEF,  0, 0, 6'd45, '0, 24'h123456);
            6:  r.item = mk(MODE_COEF,  0, 1, 6'd63, '0, 24'h7FFFFF);
            // invalid count, largest valid count, out-of-range beam
            7:  r.item = mk(MODE_COUNT, 1, 0, 6'd0,  32'hFFFFFFFF, 24'h800000);
            8:  r.item = mk(MODE_COUNT, 1, 0, 6'd0,  32'hFFFFFFFE, 24'h800000);
            9:  r.item = mk(MODE_COUNT, 0, 1, 6'd44, 32'h0FFFFFFE, 24'h7FFFFF);
            10: r.item = mk(MODE_COUNT, 0, 1, 6'd63, 32'h0FFFFFFE, '0);
            // power sums: top bits dropped, edge slots, out-of-range slots
            11: r.item = mk(MODE_SUM,   1, 0, 6'd0,  32'hFFFFFFFF, '1);
            12: r.item = mk(MODE_SUM,   0, 0, 6'd15, 32'h0FFFFFFF, '0);
            13: r.item = mk(MODE_SUM,   0, 1, 6'd16, 32'h0FFFFFFF, '0);
            14: r.item = mk(MODE_SUM,   1, 1, 6'd63, 32'h0FFFFFFF, '1);
            // detector not ready, then ready with large accumulators
            15: r.item = mk(MODE_TICK,  0, 0, 6'd0,  '0, '0);
            16: r.item = mk(MODE_TICK,  1, 1, 6'd63, '1, '1);
            // smallest weights; negative result clips
            17: r.item = mk(MODE_COEF,  0, 0, 6'd1,  '0, 24'h000001);
            18: r.item = mk(MODE_COUNT, 0, 0, 6'd1,  32'h00000001, '0);
            19: r.item = mk(MODE_SUM,   0, 0, 6'd2,  '0, '0);
            20: begin r.item = mk(MODE_TICK, 1, 0, 6'd0, '0, '0); r.typed = 1; end
            default: r.item = mk(MODE_TICK, 1, 0, 6'd0, '0, '0);
        endcase
        return r;
    endfunction

    // Roughly log-distributed count so that results are not always saturated
    function automatic logic [READING_W-1:0] shaped_reading();
        logic [READING_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       r[CNT_W-1:0] = CNT_INVALID;
            1:       r[CNT_W-1:0] = CNT_INVALID - 1'b1;
            2:       r[CNT_W-1:0] = '0;
            default: r[CNT_W-1:0] = r[CNT_W-1:0] >> $urandom_range(0, CNT_W - 1);
        endcase
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] shaped_gain();
        logic signed [COEF_W-1:0] c;
        c = COEF_W'($urandom);
        case ($urandom_range(0, 9))
            0:       c = 24'h7FFFFF;
            1:       c = 24'h800000;
            default: c = c >>> $urandom_range(0, COEF_W - 1);
        endcase
        return c;
    endfunction

    // Random transaction. In-range counts only hit beams whose gain was loaded.
    function automatic t_in_item gen_item();
        t_in_item          it;
        int                pick;
        logic [SLOT_W-1:0] s;
        it   = mk(MODE_TICK, 1'($urandom), 1'($urandom), SLOT_W'($urandom), $urandom,
                  COEF_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            it.mode        = MODE_COEF;
            it.slot        = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(BEAMS, 63))
                                                         : SLOT_W'($urandom_range(0, BEAMS - 1));
            it.coefficient = shaped_gain();
        end else if (pick < 50) begin
            it.mode    = MODE_COUNT;
            it.reading = shaped_reading();
            if ($urandom_range(0, 9) == 0) begin
                it.slot = SLOT_W'($urandom_range(BEAMS, 63));
            end else begin
                s = SLOT_W'($urandom_range(0, BEAMS - 1));
                for (int k = 0; k < 16 && !gain_written[s][it.antenna]; k++)
                    s = SLOT_W'($urandom_range(0, BEAMS - 1));
                it.slot = s;
                if (!gain_written[s][it.antenna]) begin
                    // no loaded beam found for this antenna: load instead
                    it.mode        = MODE_COEF;
                    it.coefficient = shaped_gain();
                end
            end
        end else if (pick < 75) begin
            it.mode    = MODE_SUM;
            it.slot    = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(SUM_SLOTS, 63))
                                                     : SLOT_W'($urandom_range(0, SUM_SLOTS - 1));
            it.reading = shaped_reading();
        end else begin
            it.ready_req = ($urandom_range(0, 2) == 0);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input channel driver
    // ------------------------------------------------------------------------
    task automatic drive_item(input t_in_item it, input bit keep);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_item(it, keep);
    endtask

    task automatic push_typed(input t_outcome oc);
        t_out_item r;
        r         = '0;
        r.outcome = oc;
        r.last    = 1'b1;
        if (oc == OC_POWER) begin
            r.last = 1'b0;
            pending_results.push_back(r);
            r.result_antenna = 1'b1;
            r.last           = 1'b1;
        end
        pending_results.push_back(r);
    endtask

    // Stop offering and let the block go quiet. Items without results may
    // still sit in the command queue, hence the extra cycles.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (48) @(posedge i_clk);
    endtask

    // Registers are only written with the block idle
    task automatic write_settings(input logic [TICK_W-1:0] t, input logic [SLOPE_W-1:0] sl,
                                  input logic [OFFSET_W-1:0] of);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_TIMEOUT;
        i_cfg_wdata <= CFG_W'(t);
        @(posedge i_clk);
        cfg_timeout = t;
        i_cfg_idx   <= CFG_SLOPE;
        i_cfg_wdata <= sl;
        @(posedge i_clk);
        cfg_slope   = sl;
        i_cfg_idx   <= CFG_OFFSET;
        i_cfg_wdata <= of;
        @(posedge i_clk);
        cfg_offset  = of;
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checker and receiver stall
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (mismatch_count < 100)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 100)
                    $display("%0t: unexpected result, expected none actual %p", $time, o_out);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("outcome",        32'(want.outcome),        32'(o_out.outcome));
                check_field("result_antenna", 32'(want.result_antenna),
                            32'(o_out.result_antenna));
                check_field("power_tenths",   32'(want.power_tenths),
                            32'(o_out.power_tenths));
                check_field("clipped",        32'(want.clipped),        32'(o_out.clipped));
                check_field("last",           32'(want.last),           32'(o_out.last));
            end
        end
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_step_row row;
        t_in_item  it;

        cfg_timeout = TIMEOUT_RST;
        cfg_slope   = SLOPE_RST;
        cfg_offset  = OFFSET_RST;
        tick_cnt    = '0;
        for (int a = 0; a < ANTENNAS; a++) begin
            weighted_acc[a] = '0;
            power_acc[a]    = '0;
            for (int b = 0; b < BEAMS; b++) begin
                gain_table[b][a]   = '0;
                gain_written[b][a] = 1'b0;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles a third of the time, receiver two thirds
        tx_idle_pct = 33;
        rx_idle_pct = 66;

        // directed table, reset register values
        for (int n = 0; n < N_DIRECTED; n++) begin
            row = directed_row(n);
            drive_item(row.item, !row.typed);
            if (row.typed) push_typed(row.typed_oc);
        end

        // random phases under several register settings
        for (int p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: ;  // keep reset values
                1: write_settings(8'd1, '0, '0);
                2: write_settings('1, '1, '1);
                3: write_settings('0, SLOPE_W'($urandom), OFFSET_W'($urandom));   // zero timeout
                4: write_settings(8'd3, SLOPE_W'($urandom), OFFSET_W'($urandom));
                default: write_settings(TICK_W'($urandom_range(1, 255)), SLOPE_W'($urandom),
                                        OFFSET_W'($urandom));
            endcase
            if (p == 2) begin
                tx_idle_pct = 66;
                rx_idle_pct = 33;
                // receiver holds off while items keep coming: queue fills up
                hold_requests++;
            end else if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = gen_item();
                drive_item(it, 1'b1);
            end
        end

        // full-scale weights of both signs, then power sums up to saturation
        drive_item(mk(MODE_COEF, 0, 0, 6'd7, '0, 24'h7FFFFF), 1'b1);
        drive_item(mk(MODE_COEF, 0, 1, 6'd7, '0, 24'h800000), 1'b1);
        repeat (SAT_ROUNDS) begin
            drive_item(mk(MODE_COUNT, 0, 0, 6'd7, 32'h0FFFFFFE, '0), 1'b1);
            drive_item(mk(MODE_COUNT, 0, 1, 6'd7, 32'hFFFFFFFE, '0), 1'b1);
        end
        repeat (17) begin
            drive_item(mk(MODE_SUM, 0, 0, 6'd5, 32'h0FFFFFFF, '0), 1'b1);
            drive_item(mk(MODE_SUM, 0, 1, 6'd9, 32'h0FFFFFFF, '0), 1'b1);
        end
        if (tick_cnt == 0)
            drive_item(mk(MODE_TICK, 1, 0, 6'd0, '0, '0), 1'b1);
        drive_item(mk(MODE_TICK, 1, 0, 6'd0, '0, '0), 1'b1);

        // wait out the last results, then watch for strays
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tpd_pkg.sv
sv/tpd_front.sv
sv/tpd_queue.sv
sv/tpd_pwr_mul.sv
sv/tpd_back.sv
sv/tx_power_detect_calc_core.sv
tb/sv/testbench.sv
